// ===== hdl/input_event_ring_queue_unit_macros.svh =====
// ============================================================================
// Input event ring queue: assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ============================================================================
`ifndef INPUT_EVENT_RING_QUEUE_UNIT_MACROS_SVH
`define INPUT_EVENT_RING_QUEUE_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define IEQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define IEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ieq_pkg.sv =====
// ============================================================================
// Input event ring queue package
// Sizes, codes, transaction types and helpers shared by the queue modules.
// ============================================================================
package ieq_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 512;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // Key bit store: rows of 32 bits
    localparam int KEY_LIMIT    = 767;
    localparam int KEY_ENTRIES  = KEY_LIMIT + 1;
    localparam int KEY_COL_W    = 5;
    localparam int KEY_ROW_BITS = 1 << KEY_COL_W;
    localparam int KEY_ROWS     = (KEY_ENTRIES + KEY_ROW_BITS - 1) / KEY_ROW_BITS;
    localparam int KEY_ROW_W    = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;

    // Event kinds and marker code
    localparam logic [4:0]  KIND_SYNC    = 5'h00;
    localparam logic [4:0]  KIND_KEY     = 5'h01;
    localparam logic [15:0] CODE_DROPPED = 16'd3;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_OPEN  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_EVENT   = 2'd0,
        STAT_DROPPED = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_KEY     = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Request transaction
    typedef struct packed {
        cmd_t               cmd;
        logic [4:0]         ev_type;
        logic [15:0]        ev_code;
        logic signed [31:0] ev_value;
        logic [31:0]        now_sec;
        logic [19:0]        now_usec;
    } req_t;

    // Response transaction
    typedef struct packed {
        status_t            status;
        logic [4:0]         out_type;
        logic [15:0]        out_code;
        logic signed [31:0] out_value;
        logic [31:0]        out_sec;
        logic [19:0]        out_usec;
        logic               key_down;
    } rsp_t;

    // One ring slot
    typedef struct packed {
        logic [4:0]  ev_type;
        logic [15:0] ev_code;
        logic [31:0] ev_value;
        logic [31:0] sec;
        logic [19:0] usec;
    } ring_entry_t;

    // Key store read request and update
    typedef struct packed {
        logic                 en;
        logic [KEY_ROW_W-1:0] row;
        logic [KEY_COL_W-1:0] col;
    } key_rd_t;

    typedef struct packed {
        logic wr;
        logic val;
    } key_upd_t;

    // Advance a ring slot with wrap at the ring depth
    function automatic logic [RING_AW-1:0] slot_inc(input logic [RING_AW-1:0] s);
        logic [RING_AW-1:0] r;
        if (s == RING_AW'(RING_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + RING_AW'(1);
        end
        return r;
    endfunction

endpackage

// ===== hdl/ieq_ring_mem.sv =====
// ============================================================================
// Ring event memory
// One write port and one registered read port over the event slots.
// ============================================================================
module ieq_ring_mem
    import ieq_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [RING_AW-1:0] wr_addr,
    input  ring_entry_t        wr_data,
    input  logic               rd_en,
    input  logic [RING_AW-1:0] rd_addr,
    output ring_entry_t        rd_data
);

    ring_entry_t mem [RING_DEPTH];
    ring_entry_t rd_data_reg;

    // Store a pushed event
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Fetch a slot and hold it until the next fetch
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ieq_key_store.sv =====
// ============================================================================
// Key bit store
// Row memory of key bits with per-row valid flags cleared at reset.
// ============================================================================
module ieq_key_store
    import ieq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  key_rd_t  rd,
    input  key_upd_t upd,
    output logic     key_bit
);

    logic [KEY_ROW_BITS-1:0] mem [KEY_ROWS];
    logic [KEY_ROW_BITS-1:0] rd_data_reg;
    logic [KEY_ROW_W-1:0]    row_reg;
    logic [KEY_COL_W-1:0]    col_reg;
    logic                    rd_hit_reg;
    logic [KEY_ROWS-1:0]     row_valid_reg;
    logic [KEY_ROWS-1:0]     row_valid_next;
    logic [KEY_ROW_BITS-1:0] eff_row;
    logic [KEY_ROW_BITS-1:0] new_row;

    // Fetch the addressed row
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.row];
            row_reg     <= rd.row;
            col_reg     <= rd.col;
        end
    end

    // Capture whether the fetched row was ever written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_hit_reg    <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            if (rd.en)
            begin
                rd_hit_reg <= row_valid_reg[rd.row];
            end
            row_valid_reg <= row_valid_next;
        end
    end

    // Treat an unwritten row as all released
    always_comb
    begin
        eff_row          = rd_hit_reg ? rd_data_reg : '0;
        new_row          = eff_row;
        new_row[col_reg] = upd.val;
        row_valid_next   = row_valid_reg;
        if (upd.wr)
        begin
            row_valid_next[row_reg] = 1'b1;
        end
    end

    // Write back the modified row
    always_ff @(posedge clk)
    begin
        if (upd.wr)
        begin
            mem[row_reg] <= new_row;
        end
    end

    assign key_bit = eff_row[col_reg];

endmodule

// ===== hdl/input_event_ring_queue_unit.sv =====
// ============================================================================
// Input event ring queue unit
// Time-stamped event ring with dropped-event marker and key state bits.
// ============================================================================
// Requests come in on req (valid/stall); read and query transactions give one
// response on rsp (valid/stall), push and open give none.
// Each request is accepted in idle, and the accept cycle issues the synchronous
// reads of the ring slot and the key row; the execute state then modifies and
// writes back and loads the response register. No new request is taken until
// execute finishes; the response register is loaded as execute finishes.
// The response register lets the next request be accepted while a response
// waits. If a second response is ready while the first is still stalled, the
// unit holds in its execute cycle and stalls req until rsp drains.
// Reset zeroes the write count and read position and clears the key row
// valid flags at once, so all keys read as released; no clearing pass runs.
// Ring slots hold whatever was last pushed; a read only reaches pushed slots.
// ============================================================================
`include "input_event_ring_queue_unit_macros.svh"

module input_event_ring_queue_unit
    import ieq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t             state_reg, state_next;
    req_t               item_reg;
    logic [63:0]        wc_reg, wc_next;
    logic [63:0]        rp_reg, rp_next;
    logic [RING_AW-1:0] wr_slot_reg, wr_slot_next;
    logic [RING_AW-1:0] rd_slot_reg, rd_slot_next;
    logic [63:0]        pos_reg;
    logic [RING_AW-1:0] pos_slot_reg;
    logic               key_ok_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_new;

    logic               accept;
    logic               finish;
    logic               need_rsp;
    logic               rsp_free;
    logic               clamp;
    logic [63:0]        pos_c;
    logic [RING_AW-1:0] slot_c;
    logic               req_key_ok;
    logic [63:0]        diff;
    logic               is_drop;
    logic               is_event;
    logic               ring_wr_en;
    ring_entry_t        ring_wr_data;
    logic               ring_rd_en;
    ring_entry_t        ring_rd_data;
    key_rd_t            key_rd;
    key_upd_t           key_upd;
    logic               key_bit;

    assign accept = req_valid && !req_stall;

    // Clamp the read position to the write count
    always_comb
    begin
        clamp      = rp_reg > wc_reg;
        pos_c      = clamp ? wc_reg : rp_reg;
        slot_c     = clamp ? wr_slot_reg : rd_slot_reg;
        req_key_ok = req.ev_code <= 16'(KEY_LIMIT);
    end

    // Issue the memory reads for an accepted transaction
    always_comb
    begin
        ring_rd_en = accept && (req.cmd == CMD_READ);
        key_rd.en  = accept && req_key_ok &&
                     ((req.cmd == CMD_PUSH) || (req.cmd == CMD_QUERY));
        key_rd.row = req.ev_code[KEY_COL_W +: KEY_ROW_W];
        key_rd.col = req.ev_code[KEY_COL_W-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        need_rsp  = (item_reg.cmd == CMD_READ) || (item_reg.cmd == CMD_QUERY);
        rsp_free  = !rsp_valid_reg || !rsp_stall;
        req_stall = 1'b1;
        finish    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ST_EXEC:
            begin
                finish = !need_rsp || rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // Classify a read against the write count
    always_comb
    begin
        diff     = wc_reg - pos_reg;
        is_drop  = diff > 64'(RING_DEPTH);
        is_event = diff != 64'd0;
    end

    // Update counters and build the response
    always_comb
    begin
        wc_next      = wc_reg;
        rp_next      = rp_reg;
        wr_slot_next = wr_slot_reg;
        rd_slot_next = rd_slot_reg;
        rsp_new      = '0;
        ring_wr_en   = 1'b0;
        key_upd.wr   = 1'b0;
        key_upd.val  = item_reg.ev_value != 32'sd0;

        ring_wr_data.ev_type  = item_reg.ev_type;
        ring_wr_data.ev_code  = item_reg.ev_code;
        ring_wr_data.ev_value = item_reg.ev_value;
        ring_wr_data.sec      = item_reg.now_sec;
        ring_wr_data.usec     = item_reg.now_usec;

        case (item_reg.cmd)
            CMD_PUSH:
            begin
                ring_wr_en   = finish;
                wc_next      = wc_reg + 64'd1;
                wr_slot_next = slot_inc(wr_slot_reg);
                key_upd.wr   = finish && key_ok_reg && (item_reg.ev_type == KIND_KEY);
            end
            CMD_READ:
            begin
                if (is_drop)
                begin
                    rp_next          = wc_reg;
                    rd_slot_next     = wr_slot_reg;
                    rsp_new.status   = STAT_DROPPED;
                    rsp_new.out_type = KIND_SYNC;
                    rsp_new.out_code = CODE_DROPPED;
                    rsp_new.out_sec  = item_reg.now_sec;
                    rsp_new.out_usec = item_reg.now_usec;
                end
                else if (is_event)
                begin
                    rp_next           = pos_reg + 64'd1;
                    rd_slot_next      = slot_inc(pos_slot_reg);
                    rsp_new.status    = STAT_EVENT;
                    rsp_new.out_type  = ring_rd_data.ev_type;
                    rsp_new.out_code  = ring_rd_data.ev_code;
                    rsp_new.out_value = ring_rd_data.ev_value;
                    rsp_new.out_sec   = ring_rd_data.sec;
                    rsp_new.out_usec  = ring_rd_data.usec;
                end
                else
                begin
                    rp_next        = pos_reg;
                    rd_slot_next   = pos_slot_reg;
                    rsp_new.status = STAT_EMPTY;
                end
            end
            CMD_QUERY:
            begin
                rsp_new.status   = STAT_KEY;
                rsp_new.key_down = key_ok_reg && key_bit;
            end
            CMD_OPEN:
            begin
                rp_next      = wc_reg;
                rd_slot_next = wr_slot_reg;
            end
            default:
            begin
                rsp_new = '0;
            end
        endcase
    end

    // Hold or drain the response register
    always_comb
    begin
        if (finish && need_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_free)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wc_reg        <= '0;
            rp_reg        <= '0;
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (finish)
            begin
                wc_reg      <= wc_next;
                rp_reg      <= rp_next;
                wr_slot_reg <= wr_slot_next;
                rd_slot_reg <= rd_slot_next;
            end
        end
    end

    // Capture the accepted transaction and its clamped read position; load the response
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg     <= req;
            pos_reg      <= pos_c;
            pos_slot_reg <= slot_c;
            key_ok_reg   <= req_key_ok;
        end
        if (finish && need_rsp)
        begin
            rsp_reg <= rsp_new;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    ieq_ring_mem u_ring
    (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (wr_slot_reg),
        .wr_data (ring_wr_data),
        .rd_en   (ring_rd_en),
        .rd_addr (slot_c),
        .rd_data (ring_rd_data)
    );

    ieq_key_store u_keys
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (key_rd),
        .upd     (key_upd),
        .key_bit (key_bit)
    );

    // Assertions
    `IEQ_ASSERT_NEXT(a_accept_exec, accept, state_reg == ST_EXEC, "accept did not enter execute")
    `IEQ_ASSERT_NEXT(a_push_count, finish && (item_reg.cmd == CMD_PUSH), wc_reg == $past(wc_reg) + 64'd1, "push did not advance write count")
    `IEQ_ASSERT_NEXT(a_wait_hold, (state_reg == ST_EXEC) && !finish, (state_reg == ST_EXEC) && $stable(item_reg), "waiting transaction changed")
    `IEQ_ASSERT_SAME(a_rsp_source, $rose(rsp_valid_reg), $past(state_reg == ST_EXEC), "response raised outside execute")

endmodule

// ===== verif/input_event_ring_queue_unit_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Input event ring queue unit testbench
// Sends push, read, key query and open transactions through the request
// channel and checks every response against a cycle-free model of the ring,
// the read position and the key bits. The run starts with a short directed
// sequence and then moves on to random phases: push and read runs, key
// presses with queries, opens, noise, one exactly full ring and one overrun
// that yields a dropped marker. Both channels idle at random, and the
// response side holds off once for a long stretch.
// ============================================================================
module input_event_ring_queue_unit_test;
    import ieq_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int ITEM_TARGET     = 1400;
    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 20;
    localparam int DRAIN_CYCLES    = 20;
    localparam int FULL_RING_PHASE = 4;
    localparam int OVERRUN_PHASE   = 12;

    localparam logic [4:0] KIND_REL = 5'd2;

    // Model of the queue: ring, counters, key bits and the responses due
    class event_queue_scoreboard;
        ring_entry_t ring [RING_DEPTH];
        logic [63:0] write_total;
        logic [63:0] read_at;
        bit          key_held [KEY_ENTRIES];
        rsp_t        replies_due [$];
        int          mismatches;
        int          replies_seen;

        function new();
            write_total  = '0;
            read_at      = '0;
            mismatches   = 0;
            replies_seen = 0;
            foreach (key_held[i])
            begin
                key_held[i] = 1'b0;
            end
        endfunction

        // Print one line per mismatch and count it
        task report(string what);
            $display("%0t: mismatch: %s", $time, what);
            mismatches++;
        endtask

        // Apply one accepted request and queue the response it causes
        function void note_request(req_t item);
            rsp_t        reply;
            logic [63:0] pos;
            int          slot;
            reply = '0;
            case (item.cmd)
                CMD_PUSH:
                begin
                    slot = int'(write_total % 64'(RING_DEPTH));
                    ring[slot].ev_type  = item.ev_type;
                    ring[slot].ev_code  = item.ev_code;
                    ring[slot].ev_value = item.ev_value;
                    ring[slot].sec      = item.now_sec;
                    ring[slot].usec     = item.now_usec;
                    write_total = write_total + 64'd1;
                    if (item.ev_type == KIND_KEY && item.ev_code <= KEY_LIMIT)
                    begin
                        key_held[item.ev_code] = (item.ev_value != 0);
                    end
                end
                CMD_READ:
                begin
                    pos = (read_at > write_total) ? write_total : read_at;
                    if (write_total - pos > 64'(RING_DEPTH))
                    begin
                        // Reader overrun: emit the marker and skip ahead
                        read_at         = write_total;
                        reply.status    = STAT_DROPPED;
                        reply.out_type  = KIND_SYNC;
                        reply.out_code  = CODE_DROPPED;
                        reply.out_sec   = item.now_sec;
                        reply.out_usec  = item.now_usec;
                    end
                    else if (pos < write_total)
                    begin
                        slot = int'(pos % 64'(RING_DEPTH));
                        read_at         = pos + 64'd1;
                        reply.status    = STAT_EVENT;
                        reply.out_type  = ring[slot].ev_type;
                        reply.out_code  = ring[slot].ev_code;
                        reply.out_value = ring[slot].ev_value;
                        reply.out_sec   = ring[slot].sec;
                        reply.out_usec  = ring[slot].usec;
                    end
                    else
                    begin
                        read_at      = pos;
                        reply.status = STAT_EMPTY;
                    end
                    replies_due.push_back(reply);
                end
                CMD_QUERY:
                begin
                    reply.status = STAT_KEY;
                    if (item.ev_code <= KEY_LIMIT)
                    begin
                        reply.key_down = key_held[item.ev_code];
                    end
                    replies_due.push_back(reply);
                end
                CMD_OPEN:
                begin
                    read_at = write_total;
                end
            endcase
        endfunction

        // Compare one accepted response with the oldest one due
        task check_response(rsp_t got);
            rsp_t want;
            replies_seen++;
            if (replies_due.size() == 0)
            begin
                report($sformatf("response %0d with none pending, status %0d",
                                 replies_seen, got.status));
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status)
                report($sformatf("response %0d status %0d, want %0d",
                                 replies_seen, got.status, want.status));
            if (got.out_type !== want.out_type)
                report($sformatf("response %0d type %0d, want %0d",
                                 replies_seen, got.out_type, want.out_type));
            if (got.out_code !== want.out_code)
                report($sformatf("response %0d code %0d, want %0d",
                                 replies_seen, got.out_code, want.out_code));
            if (got.out_value !== want.out_value)
                report($sformatf("response %0d value %0d, want %0d",
                                 replies_seen, got.out_value, want.out_value));
            if (got.out_sec !== want.out_sec)
                report($sformatf("response %0d sec %0d, want %0d",
                                 replies_seen, got.out_sec, want.out_sec));
            if (got.out_usec !== want.out_usec)
                report($sformatf("response %0d usec %0d, want %0d",
                                 replies_seen, got.out_usec, want.out_usec));
            if (got.key_down !== want.key_down)
                report($sformatf("response %0d key_down %0d, want %0d",
                                 replies_seen, got.key_down, want.key_down));
        endtask
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    event_queue_scoreboard queue_model;
    int                    items_sent = 0;
    int                    quiet_cycles = 0;

    input_event_ring_queue_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #(HALF_PERIOD);
        clk = ~clk;
    end

    // Check every accepted response transaction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            queue_model.check_response(rsp);
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("input_event_ring_queue_unit test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic req_t make_request(cmd_t op, logic [4:0] kind,
                                          logic [15:0] code, logic [31:0] value,
                                          logic [31:0] sec, logic [19:0] usec);
        req_t item;
        item.cmd      = op;
        item.ev_type  = kind;
        item.ev_code  = code;
        item.ev_value = value;
        item.now_sec  = sec;
        item.now_usec = usec;
        return item;
    endfunction

    // Random content, weighted toward key events and key codes in range
    function automatic req_t random_request(cmd_t op);
        req_t item;
        item.cmd = op;
        case ($urandom_range(0, 5))
            0, 1:    item.ev_type = KIND_KEY;
            2:       item.ev_type = KIND_SYNC;
            3:       item.ev_type = KIND_REL;
            default: item.ev_type = 5'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0)
            item.ev_code = 16'($urandom);
        else
            item.ev_code = 16'($urandom_range(0, KEY_LIMIT));
        case ($urandom_range(0, 3))
            0:       item.ev_value = '0;
            1:       item.ev_value = 32'd1;
            default: item.ev_value = 32'($urandom);
        endcase
        item.now_sec = $urandom;
        if ($urandom_range(0, 7) == 0)
            item.now_usec = 20'($urandom);
        else
            item.now_usec = 20'($urandom_range(0, 999999));
        return item;
    endfunction

    // Idle the request side for a random gap, mostly short
    task automatic pause_sender(bit steady);
        int pick;
        int gap;
        if (steady)
            return;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            gap = 0;
        else if (pick < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Offer one request transaction and hold it until accepted
    task automatic send(req_t item, bit steady);
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        queue_model.note_request(item);
        items_sent++;
        pause_sender(steady);
    endtask

    task automatic run_phase(int phase);
        bit          steady;
        int          count;
        req_t        item;
        logic [15:0] code;
        steady = ($urandom_range(0, 3) == 0);
        if (phase == FULL_RING_PHASE)
        begin
            // Fill exactly one ring: the oldest event must still come back
            send(random_request(CMD_OPEN), steady);
            repeat (RING_DEPTH) send(random_request(CMD_PUSH), steady);
            repeat (2) send(random_request(CMD_READ), steady);
            send(random_request(CMD_OPEN), steady);
        end
        else if (phase == OVERRUN_PHASE)
        begin
            // Overrun the ring: dropped marker, then empty, then fresh events
            send(random_request(CMD_OPEN), steady);
            count = $urandom_range(RING_DEPTH + 1, RING_DEPTH + 24);
            repeat (count) send(random_request(CMD_PUSH), steady);
            repeat (3) send(random_request(CMD_READ), steady);
            repeat (2) send(random_request(CMD_PUSH), steady);
            repeat (3) send(random_request(CMD_READ), steady);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    // Push a run, then read it back and past its end
                    count = $urandom_range(1, 16);
                    repeat (count) send(random_request(CMD_PUSH), steady);
                    repeat (count + $urandom_range(0, 2))
                        send(random_request(CMD_READ), steady);
                end
                1:
                begin
                    // Noise: any command with random content
                    repeat ($urandom_range(1, 10))
                        send(random_request(cmd_t'($urandom_range(0, 3))), steady);
                end
                2:
                begin
                    // Press or release keys and query them right after
                    repeat ($urandom_range(1, 6))
                    begin
                        case ($urandom_range(0, 5))
                            0:       code = 16'(KEY_LIMIT);
                            1:       code = 16'(KEY_LIMIT + 1);
                            2:       code = '0;
                            default: code = 16'($urandom_range(0, KEY_LIMIT));
                        endcase
                        item = random_request(CMD_PUSH);
                        item.ev_type = KIND_KEY;
                        item.ev_code = code;
                        send(item, steady);
                        item = random_request(CMD_QUERY);
                        item.ev_code = code;
                        send(item, steady);
                        if ($urandom_range(0, 2) == 0)
                            send(random_request(CMD_QUERY), steady);
                    end
                end
                default:
                begin
                    // Open, then a few pushes and reads
                    send(random_request(CMD_OPEN), steady);
                    repeat ($urandom_range(0, 5)) send(random_request(CMD_PUSH), steady);
                    repeat ($urandom_range(0, 6)) send(random_request(CMD_READ), steady);
                end
            endcase
        end
    endtask

    // Response side: random stalls and one long hold-off
    initial
    begin : reply_side
        bit held;
        int pick;
        int span;
        held = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && queue_model.replies_seen >= HOLD_OFF_AFTER)
            begin
                held = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    rsp_stall <= 1'b0;
                    span = $urandom_range(1, 20);
                end
                else if (pick < 85)
                begin
                    rsp_stall <= 1'b1;
                    span = $urandom_range(1, 3);
                end
                else if (pick < 95)
                begin
                    rsp_stall <= 1'b0;
                    span = $urandom_range(30, 80);
                end
                else
                begin
                    rsp_stall <= 1'b1;
                    span = $urandom_range(10, 40);
                end
                repeat (span) @(posedge clk);
            end
        end
    end

    // Request side: reset, directed sequence, random phases, drain
    initial
    begin : stimulus
        int phase;
        queue_model = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue, released key, open with nothing written
        send(make_request(CMD_READ, '0, '0, '0, 32'hFFFF_FFFF, 20'hFFFFF), 1'b0);
        send(make_request(CMD_QUERY, '0, '0, '0, '0, '0), 1'b0);
        send(make_request(CMD_OPEN, '0, '0, '0, '0, '0), 1'b0);

        // Field extremes; key codes at, above and far above the key limit
        send(make_request(CMD_PUSH, KIND_KEY, '0, 32'd1, '0, '0), 1'b0);
        send(make_request(CMD_PUSH, KIND_KEY, 16'(KEY_LIMIT), 32'h8000_0000,
                          32'hFFFF_FFFF, 20'hFFFFF), 1'b0);
        send(make_request(CMD_PUSH, KIND_KEY, 16'(KEY_LIMIT + 1), 32'd1,
                          32'd1, 20'd999999), 1'b0);
        send(make_request(CMD_PUSH, KIND_KEY, 16'hFFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 20'd1000000), 1'b0);
        send(make_request(CMD_PUSH, 5'h1F, 16'hFFFF, 32'hFFFF_FFFF,
                          32'h5555_5555, 20'hAAAAA), 1'b0);
        send(make_request(CMD_PUSH, KIND_SYNC, '0, '0, 32'hAAAA_AAAA, 20'h55555), 1'b0);
        send(make_request(CMD_PUSH, KIND_KEY, '0, '0, 32'd7, 20'd7), 1'b0);

        // Key bits: released, held at the limit, ignored above it
        send(make_request(CMD_QUERY, '0, '0, '0, '0, '0), 1'b0);
        send(make_request(CMD_QUERY, '0, 16'(KEY_LIMIT), '0, '0, '0), 1'b0);
        send(make_request(CMD_QUERY, '0, 16'(KEY_LIMIT + 1), '0, '0, '0), 1'b0);
        send(make_request(CMD_QUERY, '0, 16'hFFFF, '0, '0, '0), 1'b0);

        // Read back all seven events, then one read past the end
        repeat (8) send(make_request(CMD_READ, '0, '0, '0, '0, '0), 1'b0);

        // Open skips unread events
        send(make_request(CMD_PUSH, KIND_REL, 16'd1, 32'hFFFF_FFFB, 32'd9, 20'd9), 1'b0);
        send(make_request(CMD_OPEN, '0, '0, '0, '0, '0), 1'b0);
        send(make_request(CMD_READ, '0, '0, '0, '0, '0), 1'b0);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            run_phase(phase);
            phase++;
        end
        req_valid <= 1'b0;

        // Wait for every response due, then let the pipeline settle
        while (queue_model.replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (queue_model.mismatches == 0 && queue_model.replies_due.size() == 0)
        begin
            $display("input_event_ring_queue_unit test passed");
        end
        else
        begin
            $display("input_event_ring_queue_unit test failed");
        end
        $finish;
    end

endmodule
